FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk and quiet during rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define GBTS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition must never be seen outside reset.
`define GBTS_ASSERT_NEVER(label, cond, msg) \
  `GBTS_ASSERT(label, !(cond), msg)

`endif

FILE: hw/rtl/gbts_pkg.sv
// ----------------------------------------------------------------------------
// gbts_pkg
// Sizes, request and status codes, and the shift step record of the gap
// buffer text store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gbts_pkg;

  localparam int DEPTH    = 1024;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int POS_W    = 10;
  localparam int CH_W     = 8;
  localparam int MODE_W   = 2;
  localparam int STATUS_W = 2;
  // common width for comparing a position against a length
  localparam int CNT_W    = (ADDR_W > POS_W) ? ADDR_W : POS_W;

  typedef logic [ADDR_W-1:0] addr_t;

  localparam addr_t LAST_CELL = addr_t'(DEPTH - 1);

  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MOVE   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_READ   = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // one character move across the gap
  typedef struct packed {
    logic  at_target;   // cursor already at target, nothing to move
    logic  left;        // gap moves toward cell zero
    addr_t src;         // cell read
    addr_t dst;         // cell written
    addr_t first_next;  // gap start after the move
    addr_t last_next;   // gap end after the move
  } step_t;

endpackage

FILE: hw/rtl/gbts_if.sv
// ----------------------------------------------------------------------------
// gbts_if
// Request and result channels of the gap buffer text store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface gbts_req_if;
  logic                          valid;
  logic                          ready;
  logic [gbts_pkg::MODE_W-1:0]   mode;
  logic [gbts_pkg::POS_W-1:0]    position;
  logic [gbts_pkg::CH_W-1:0]     ch;

  modport source (output valid, mode, position, ch, input ready);
  modport sink   (input valid, mode, position, ch, output ready);
endinterface

interface gbts_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [gbts_pkg::STATUS_W-1:0] status;
  logic [gbts_pkg::CH_W-1:0]     read_byte;
  logic [gbts_pkg::POS_W-1:0]    cursor;
  logic [gbts_pkg::POS_W-1:0]    text_length;

  modport source (output valid, status, read_byte, cursor, text_length, input ready);
  modport sink   (input valid, status, read_byte, cursor, text_length, output ready);
endinterface

FILE: hw/rtl/gbts_ram.sv
// ----------------------------------------------------------------------------
// gbts_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gbts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: hw/rtl/gbts_shift_unit.sv
// ----------------------------------------------------------------------------
// gbts_shift_unit
// Step unit: picks the direction of the next character move and
// the cells and gap bounds that move involves.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gbts_shift_unit (
  input  gbts_pkg::addr_t gap_first,
  input  gbts_pkg::addr_t gap_last,
  input  gbts_pkg::addr_t target,
  output gbts_pkg::step_t step
);

  logic left;
  logic right_blocked;

  assign left          = target < gap_first;
  assign right_blocked = gap_last == gbts_pkg::LAST_CELL;

  always_comb begin
    step.left      = left;
    step.at_target = (target == gap_first) || (!left && right_blocked);
    if (left) begin
      // last char of the first run goes to the top of the gap
      step.src        = gap_first - 1'b1;
      step.dst        = gap_last;
      step.first_next = gap_first - 1'b1;
      step.last_next  = gap_last - 1'b1;
    end else begin
      // first char of the second run goes to the bottom of the gap
      step.src        = gap_last + 1'b1;
      step.dst        = gap_first;
      step.first_next = gap_first + 1'b1;
      step.last_next  = gap_last + 1'b1;
    end
  end

endmodule

FILE: hw/rtl/gap_buffer_text_store_unit.sv
// ----------------------------------------------------------------------------
// Gap buffer text store
// A text buffer of DEPTH byte cells (1024) kept as two runs around a gap.
// Each request moves the cursor to a logical position by shifting one
// character across the gap per step, then inserts a byte at the cursor,
// deletes the byte before it, only moves, or (read mode) returns the byte
// at a position without moving. One result follows each request. Requests
// are taken one at a time, and each shift is one read and one write
// through the single character RAM. A finished result sits in an output
// register, so the next request may be taken while it waits; a further
// result stalls in S_DONE until that register is taken.
// At most DEPTH-1 bytes are held; an insert into a full buffer is refused.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gap_buffer_text_store_unit (
  input  logic           clk,
  input  logic           rst,
  gbts_req_if.sink       req,
  gbts_rsp_if.source     rsp
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,  // waiting for a request
    S_EVAL   = 6'b000010,  // range and full checks, read address issue
    S_MOVE   = 6'b000100,  // issue shift read, or finish edit at cursor
    S_XFER   = 6'b001000,  // write shifted char, step gap bounds
    S_RDWAIT = 6'b010000,  // capture read-mode byte
    S_DONE   = 6'b100000   // load output register
  } state_t;

  state_t state, state_next;

  // gap bounds and latched request
  gbts_pkg::addr_t                  gap_first, gap_last;
  logic [gbts_pkg::MODE_W-1:0]      req_mode;
  logic [gbts_pkg::POS_W-1:0]       req_pos;
  logic [gbts_pkg::CH_W-1:0]        req_ch;

  // result in flight and output register
  logic [gbts_pkg::STATUS_W-1:0]    res_status;
  logic [gbts_pkg::CH_W-1:0]        res_byte;
  logic                             out_valid;
  logic [gbts_pkg::STATUS_W-1:0]    out_status;
  logic [gbts_pkg::CH_W-1:0]        out_byte;
  logic [gbts_pkg::POS_W-1:0]       out_cursor;
  logic [gbts_pkg::POS_W-1:0]       out_length;
  logic                             out_refused;

  // derived values
  gbts_pkg::addr_t                  len;
  gbts_pkg::addr_t                  gap_size;
  gbts_pkg::addr_t                  target;
  gbts_pkg::addr_t                  read_idx;
  logic [gbts_pkg::CNT_W-1:0]       pos_ext, len_ext, first_ext;
  logic                             is_full, range_bad;
  logic                             out_free;
  gbts_pkg::step_t                  step;

  // RAM ports
  logic                             ram_we;
  gbts_pkg::addr_t                  ram_waddr, ram_raddr;
  logic [gbts_pkg::CH_W-1:0]        ram_wdata, ram_rdata;

  // --------------------------------------------------------------------------
  // Checks on the latched request against the current gap
  // --------------------------------------------------------------------------
  assign gap_size  = gap_last - gap_first;
  assign len       = gap_first + (gbts_pkg::LAST_CELL - gap_last);
  assign pos_ext   = gbts_pkg::CNT_W'(req_pos);
  assign len_ext   = gbts_pkg::CNT_W'(len);
  assign first_ext = gbts_pkg::CNT_W'(gap_first);
  assign is_full   = gap_first == gap_last;
  // read needs a char at the position; edits may sit at the end of text
  assign range_bad = (req_mode == gbts_pkg::MODE_READ) ? (pos_ext >= len_ext)
                                                       : (pos_ext > len_ext);
  // only used once the position is known to be within the text
  assign target    = gbts_pkg::addr_t'(req_pos);
  // positions past the cursor live above the gap
  assign read_idx  = (pos_ext < first_ext) ? target : (target + gap_size + 1'b1);

  assign out_free  = !out_valid || rsp.ready;

  gbts_shift_unit u_shift (
    .gap_first (gap_first),
    .gap_last  (gap_last),
    .target    (target),
    .step      (step)
  );

  // --------------------------------------------------------------------------
  // Character store: shift traffic, insert writes and read-mode lookups
  // --------------------------------------------------------------------------
  always_comb begin
    ram_raddr = (state == S_EVAL) ? read_idx : step.src;
    ram_we    = 1'b0;
    ram_waddr = gap_first;
    ram_wdata = req_ch;
    if (state == S_XFER) begin
      ram_we    = 1'b1;
      ram_waddr = step.dst;
      ram_wdata = ram_rdata;
    end else if (state == S_MOVE && step.at_target &&
                 req_mode == gbts_pkg::MODE_INSERT) begin
      ram_we    = 1'b1;
    end
  end

  gbts_ram #(
    .WIDTH (gbts_pkg::CH_W),
    .DEPTH (gbts_pkg::DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req.valid) state_next = S_EVAL;
      end
      S_EVAL: begin
        if ((req_mode == gbts_pkg::MODE_INSERT && is_full) || range_bad) begin
          state_next = S_DONE;
        end else if (req_mode == gbts_pkg::MODE_READ) begin
          state_next = S_RDWAIT;
        end else begin
          state_next = S_MOVE;
        end
      end
      S_MOVE: begin
        state_next = step.at_target ? S_DONE : S_XFER;
      end
      S_XFER:   state_next = S_MOVE;
      S_RDWAIT: state_next = S_DONE;
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      gap_first <= '0;
      gap_last  <= gbts_pkg::LAST_CELL;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;

      // new result loaded, or the waiting one taken downstream
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            req_mode <= req.mode;
            req_pos  <= req.position;
            req_ch   <= req.ch;
          end
        end
        S_EVAL: begin
          res_byte <= '0;
          if (req_mode == gbts_pkg::MODE_INSERT && is_full) begin
            res_status <= gbts_pkg::ST_FULL;
          end else if (range_bad) begin
            res_status <= gbts_pkg::ST_RANGE;
          end else begin
            res_status <= gbts_pkg::ST_OK;
          end
        end
        S_MOVE: begin
          if (step.at_target) begin
            priority if (req_mode == gbts_pkg::MODE_INSERT) begin
              gap_first <= gap_first + 1'b1;
            end else if (req_mode == gbts_pkg::MODE_DELETE && gap_first != '0) begin
              // backspace: char before the cursor joins the gap
              gap_first <= gap_first - 1'b1;
            end
          end
        end
        S_XFER: begin
          gap_first <= step.first_next;
          gap_last  <= step.last_next;
        end
        S_RDWAIT: begin
          res_byte <= ram_rdata;
        end
        S_DONE: begin
          if (out_free) begin
            out_status <= res_status;
            out_byte   <= res_byte;
            out_cursor <= gbts_pkg::POS_W'(gap_first);
            out_length <= gbts_pkg::POS_W'(len);
          end
        end
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Ports
  // --------------------------------------------------------------------------
  assign req.ready       = state == S_IDLE;
  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.read_byte   = out_byte;
  assign rsp.cursor      = out_cursor;
  assign rsp.text_length = out_length;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  assign out_refused = out_valid && out_status != gbts_pkg::ST_OK;

  `GBTS_ASSERT_NEVER(a_gap_kept, gap_first > gap_last, "gap lost its last free cell")
  `GBTS_ASSERT(a_shift_keeps_gap, (state == S_XFER) |=> (gap_size == $past(gap_size)), "gap resized")
  `GBTS_ASSERT(a_refused_no_byte, out_refused |-> (out_byte == '0), "refused request returned data")

endmodule
